@@ hw/rtl/lwc_pkg.sv @@
// Line window clipper package: coordinate, segment, result and window types,
// register indexes and the outcode function. No dependencies.
`default_nettype none
package lwc_pkg;
    localparam int CoordWidth = 16;
    localparam int DiffWidth  = CoordWidth + 1;
    localparam int QuoWidth   = DiffWidth;
    localparam int PushLimit  = 8;

    localparam int OcLeft   = 0;
    localparam int OcRight  = 1;
    localparam int OcBottom = 2;
    localparam int OcTop    = 3;

    typedef logic signed [CoordWidth-1:0] t_coord;
    typedef logic signed [DiffWidth-1:0]  t_diff;
    typedef logic [DiffWidth-1:0]         t_mag;

    typedef enum logic [1:0] {
        REG_WIN_LEFT   = 2'd0,
        REG_WIN_RIGHT  = 2'd1,
        REG_WIN_BOTTOM = 2'd2,
        REG_WIN_TOP    = 2'd3
    } t_reg_idx;

    typedef struct packed {
        t_coord start_x;
        t_coord start_y;
        t_coord end_x;
        t_coord end_y;
    } t_seg;

    typedef struct packed {
        t_coord out_start_x;
        t_coord out_start_y;
        t_coord out_end_x;
        t_coord out_end_y;
        logic   rejected;
    } t_res;

    typedef struct packed {
        t_coord left;
        t_coord right;
        t_coord bottom;
        t_coord top;
    } t_win;

    typedef struct packed {
        t_seg seg;
        logic triv_acc;
        logic triv_rej;
    } t_item;

    function automatic logic [3:0] outcode(t_coord x, t_coord y, t_win w);
        logic [3:0] c;
        c = '0;
        c[OcLeft]   = (x < w.left);
        c[OcRight]  = (x > w.right);
        c[OcBottom] = (y < w.bottom);
        c[OcTop]    = (y > w.top);
        return c;
    endfunction
endpackage
`default_nettype wire

@@ hw/rtl/lwc_front.sv @@
// Line window clipper front: accepts segments, flags trivial accept/reject,
// and holds them in a two-entry queue. Depends on lwc_pkg.
`default_nettype none
module lwc_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire lwc_pkg::t_win i_win,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire lwc_pkg::t_seg i_seg,
    output logic               o_q_valid,
    output lwc_pkg::t_item     o_q_item,
    input  wire logic          i_q_pop
);
    lwc_pkg::t_item r_mem [2];
    logic           r_wr_ptr, r_rd_ptr;
    logic [1:0]     r_cnt;
    logic [3:0]     cs, ce;
    logic           push;
    lwc_pkg::t_item n_item;

    always_comb begin
        cs = lwc_pkg::outcode(i_seg.start_x, i_seg.start_y, i_win);
        ce = lwc_pkg::outcode(i_seg.end_x, i_seg.end_y, i_win);
        n_item.seg      = i_seg;
        n_item.triv_acc = ((cs | ce) == 4'd0);
        n_item.triv_rej = ((cs & ce) != 4'd0);
    end

    assign o_stall   = (r_cnt == 2'd2);
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (push) r_wr_ptr <= !r_wr_ptr;
            if (i_q_pop) r_rd_ptr <= !r_rd_ptr;
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/lwc_back.sv @@
// Line window clipper back end: push sequencer with a multiplier, a
// shared restoring divider and the output register. Depends on lwc_pkg.
`default_nettype none
module lwc_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire lwc_pkg::t_win  i_win,
    input  wire logic           i_q_valid,
    input  wire lwc_pkg::t_item i_q_item,
    output logic                o_q_pop,
    output logic                o_valid,
    input  wire logic           i_stall,
    output lwc_pkg::t_res       o_res
);
    localparam int CW = lwc_pkg::CoordWidth;
    localparam int DW = lwc_pkg::DiffWidth;
    localparam int QW = lwc_pkg::QuoWidth;
    localparam int DCW = $clog2(QW + 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EVAL = 6'b000010,
        S_MUL  = 6'b000100,
        S_DIV  = 6'b001000,
        S_UPD  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state           r_state;
    lwc_pkg::t_coord  r_xs, r_ys, r_xe, r_ye;
    logic             r_rej;
    logic [3:0]       r_npush;
    lwc_pkg::t_mag    r_ma, r_mb, r_mc;
    logic             r_neg;
    logic             r_sel_end, r_free_y;
    lwc_pkg::t_coord  r_edge, r_pfree;
    lwc_pkg::t_mag    r_rem;
    logic [QW-1:0]    r_lo;
    logic [DCW-1:0]   r_dcnt;
    logic             r_out_valid;
    lwc_pkg::t_res    r_out;

    logic [3:0]       cs, ce, code;
    lwc_pkg::t_coord  px, py, ox, oy, edge_v, pfree;
    lwc_pkg::t_diff   a, b, c;
    logic             free_y;
    logic [2*DW-1:0]  prod;
    logic [DW:0]      trial;
    logic             ge;
    logic signed [DW:0] qs, sum;
    lwc_pkg::t_coord  newv;
    logic             out_free;

    function automatic lwc_pkg::t_mag mag(lwc_pkg::t_diff v);
        return v[DW-1] ? lwc_pkg::t_mag'(-v) : lwc_pkg::t_mag'(v);
    endfunction

    always_comb begin
        cs = lwc_pkg::outcode(r_xs, r_ys, i_win);
        ce = lwc_pkg::outcode(r_xe, r_ye, i_win);
        if (ce != 4'd0) begin
            code = ce; px = r_xe; py = r_ye; ox = r_xs; oy = r_ys;
        end else begin
            code = cs; px = r_xs; py = r_ys; ox = r_xe; oy = r_ye;
        end
        free_y = code[lwc_pkg::OcLeft] || code[lwc_pkg::OcRight];
        priority if (code[lwc_pkg::OcLeft]) edge_v = i_win.left;
        else if (code[lwc_pkg::OcRight])     edge_v = i_win.right;
        else if (code[lwc_pkg::OcBottom])    edge_v = i_win.bottom;
        else                                 edge_v = i_win.top;
        if (free_y) begin
            a = DW'(oy) - DW'(py);
            b = DW'(edge_v) - DW'(px);
            c = DW'(ox) - DW'(px);
            pfree = py;
        end else begin
            a = DW'(ox) - DW'(px);
            b = DW'(edge_v) - DW'(py);
            c = DW'(oy) - DW'(py);
            pfree = px;
        end
        prod  = (2*DW)'(r_ma) * (2*DW)'(r_mb);
        trial = {r_rem, r_lo[QW-1]};
        ge    = (trial >= {1'b0, r_mc});
        qs    = r_neg ? -$signed({1'b0, r_lo}) : $signed({1'b0, r_lo});
        sum   = $signed((DW+1)'(r_pfree)) + qs;
        newv  = sum[CW-1:0];
        out_free = !r_out_valid || !i_stall;
    end

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_xs    <= i_q_item.seg.start_x;
                        r_ys    <= i_q_item.seg.start_y;
                        r_xe    <= i_q_item.seg.end_x;
                        r_ye    <= i_q_item.seg.end_y;
                        r_rej   <= i_q_item.triv_rej;
                        r_npush <= 4'd0;
                        r_state <= (i_q_item.triv_rej || i_q_item.triv_acc) ? S_OUT : S_EVAL;
                    end
                end
                S_EVAL: begin
                    if ((cs | ce) == 4'd0) begin
                        r_rej   <= 1'b0;
                        r_state <= S_OUT;
                    end else if ((cs & ce) != 4'd0 || r_npush == 4'(lwc_pkg::PushLimit)) begin
                        r_rej   <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_ma      <= mag(a);
                        r_mb      <= mag(b);
                        r_mc      <= mag(c);
                        r_neg     <= a[DW-1] ^ b[DW-1] ^ c[DW-1];
                        r_sel_end <= (ce != 4'd0);
                        r_free_y  <= free_y;
                        r_edge    <= edge_v;
                        r_pfree   <= pfree;
                        r_state   <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_rem   <= prod[2*DW-1:QW];
                    r_lo    <= prod[QW-1:0];
                    r_dcnt  <= DCW'(QW);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem  <= ge ? DW'(trial - {1'b0, r_mc}) : trial[DW-1:0];
                    r_lo   <= {r_lo[QW-2:0], ge};
                    r_dcnt <= r_dcnt - DCW'(1);
                    if (r_dcnt == DCW'(1)) r_state <= S_UPD;
                end
                S_UPD: begin
                    unique case ({r_sel_end, r_free_y})
                        2'b11: begin r_ye <= newv; r_xe <= r_edge; end
                        2'b10: begin r_xe <= newv; r_ye <= r_edge; end
                        2'b01: begin r_ys <= newv; r_xs <= r_edge; end
                        default: begin r_xs <= newv; r_ys <= r_edge; end
                    endcase
                    r_npush <= r_npush + 4'd1;
                    r_state <= S_EVAL;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out.rejected    <= r_rej;
                        r_out.out_start_x <= r_rej ? '0 : r_xs;
                        r_out.out_start_y <= r_rej ? '0 : r_ys;
                        r_out.out_end_x   <= r_rej ? '0 : r_xe;
                        r_out.out_end_y   <= r_rej ? '0 : r_ye;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/line_window_clipper.sv @@
// Line window clipper top: window registers, front queue and back end.
// Depends on lwc_pkg, lwc_front, lwc_back.
//
//   channel | direction | handshake              | carries
//   in      | input     | i_in_valid/o_in_stall  | lwc_pkg::t_seg
//   out     | output    | o_out_valid/i_out_stall| lwc_pkg::t_res
//   cfg     | input     | i_cfg_valid/o_cfg_ready| index, window coordinate
//
// Trivial accept/reject: S_IDLE, then S_OUT writes the output register.
// Each edge push: evaluate, multiply, 17-step divider, update; a segment
// not accepted after eight pushes is rejected.
// Reset (synchronous) empties the queue and output and loads the default window.
// The two-entry front queue keeps taking input while the back works, until full.
`default_nettype none
module line_window_clipper (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire lwc_pkg::t_seg i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output lwc_pkg::t_res      o_out_data,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [1:0]    i_cfg_index,
    input  wire lwc_pkg::t_coord i_cfg_data
);
    lwc_pkg::t_win  r_win;
    logic           q_valid, q_pop;
    lwc_pkg::t_item q_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win.left   <= '0;
            r_win.right  <= {1'b0, {(lwc_pkg::CoordWidth-1){1'b1}}};
            r_win.bottom <= '0;
            r_win.top    <= {1'b0, {(lwc_pkg::CoordWidth-1){1'b1}}};
        end else if (i_cfg_valid) begin
            unique case (lwc_pkg::t_reg_idx'(i_cfg_index))
                lwc_pkg::REG_WIN_LEFT:   r_win.left   <= i_cfg_data;
                lwc_pkg::REG_WIN_RIGHT:  r_win.right  <= i_cfg_data;
                lwc_pkg::REG_WIN_BOTTOM: r_win.bottom <= i_cfg_data;
                lwc_pkg::REG_WIN_TOP:    r_win.top    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lwc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_win     (r_win),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_seg     (i_in_data),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    lwc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_win     (r_win),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_res     (o_out_data)
    );
endmodule
`default_nettype wire
